[hw/rtl/slip_enc_pkg.sv]
// slip_enc_pkg: byte codes, result list types and the chunk fill step
// used by the chunked slip encoder; depends on nothing
`default_nettype none

package slip_enc_pkg;

   localparam logic [7:0] FRAME_END     = 8'hC0;
   localparam logic [7:0] FRAME_ESC     = 8'hDB;
   localparam logic [7:0] FRAME_ESC_END = 8'hDC;
   localparam logic [7:0] FRAME_ESC_ESC = 8'hDD;

   localparam int          FILL_W    = 10;
   localparam int          MAX_RES   = 4;
   localparam int          RES_IDX_W = 2;
   localparam int          RES_CNT_W = 3;
   localparam logic [FILL_W-1:0] MIN_CHUNK    = 10'd3;
   localparam logic [FILL_W-1:0] CHUNK_RESET  = 10'd20;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       chunk_end;
   } slip_ent_type;

   typedef struct packed {
      slip_ent_type [MAX_RES-1:0] ent;
      logic [RES_CNT_W-1:0]       cnt;
   } slip_list_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              chunk_end;
   } fill_step_type;

   // place one byte into the open chunk
   function automatic fill_step_type put_step(input logic [FILL_W-1:0] fill,
                                              input logic [FILL_W-1:0] lim);
      fill_step_type r;
      r.fill      = fill + 1'b1;
      r.chunk_end = 1'b0;
      if ((r.fill >= lim) || (r.fill == '0)) begin
         r.chunk_end = 1'b1;
         r.fill      = '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/slip_enc_expand.sv]
// slip_enc_expand: turns one registered item into its list of encoded bytes
// and keeps chunk fill and frame state; uses slip_enc_pkg
`default_nettype none

module slip_enc_expand import slip_enc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [FILL_W-1:0] chunk_size,
   input  wire logic [7:0]        data_byte,
   input  wire logic              has_data,
   input  wire logic              last_byte,
   input  wire logic              take,
   output slip_list_type          list
);

   logic [FILL_W-1:0] chunk_fill_ff, chunk_fill_in;
   logic              in_frame_ff, in_frame_in;

   always_comb begin
      logic [FILL_W-1:0]    lim;
      logic [FILL_W-1:0]    fill;
      logic [RES_CNT_W-1:0] n;
      logic [RES_CNT_W-1:0] nm1;
      fill_step_type        s;
      slip_list_type        l;

      lim  = (chunk_size < MIN_CHUNK) ? MIN_CHUNK : chunk_size;
      fill = chunk_fill_ff;
      n    = '0;
      nm1  = '0;
      s    = '0;
      l    = '0;
      in_frame_in = in_frame_ff;

      // opening end of a new frame
      if (!in_frame_ff) begin
         s = put_step(fill, lim);
         fill = s.fill;
         l.ent[n[RES_IDX_W-1:0]] = '{byte_val: FRAME_END, chunk_end: s.chunk_end};
         n = n + 1'b1;
         in_frame_in = 1'b1;
      end

      if (has_data) begin
         s = put_step(fill, lim);
         fill = s.fill;
         if ((data_byte == FRAME_END) || (data_byte == FRAME_ESC)) begin
            l.ent[n[RES_IDX_W-1:0]] = '{byte_val: FRAME_ESC, chunk_end: s.chunk_end};
            n = n + 1'b1;
            s = put_step(fill, lim);
            fill = s.fill;
            l.ent[n[RES_IDX_W-1:0]] = '{
               byte_val: (data_byte == FRAME_END) ? FRAME_ESC_END : FRAME_ESC_ESC,
               chunk_end: s.chunk_end};
         end else begin
            l.ent[n[RES_IDX_W-1:0]] = '{byte_val: data_byte, chunk_end: s.chunk_end};
         end
         n = n + 1'b1;
      end

      // closing end: too full means the previous byte closes the chunk
      if (last_byte) begin
         if (({1'b0, fill} + 1'b1) >= {1'b0, lim} && (n != '0)) begin
            nm1 = n - 1'b1;
            l.ent[nm1[RES_IDX_W-1:0]].chunk_end = 1'b1;
         end
         l.ent[n[RES_IDX_W-1:0]] = '{byte_val: FRAME_END, chunk_end: 1'b1};
         n = n + 1'b1;
         fill = '0;
         in_frame_in = 1'b0;
      end

      l.cnt = n;
      list  = l;
      chunk_fill_in = fill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_fill_ff <= '0;
         in_frame_ff   <= 1'b0;
      end else if (take) begin
         chunk_fill_ff <= chunk_fill_in;
         in_frame_ff   <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/slip_enc_emit.sv]
// slip_enc_emit: holds one item's byte list and sends it one byte a cycle
// on the result channel while rsp_ready is high; uses slip_enc_pkg
`default_nettype none

module slip_enc_emit import slip_enc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  wire slip_list_type list,
   output logic       free,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_chunk_end,
   output logic       rsp_run_end
);

   slip_ent_type [MAX_RES-1:0] ent_ff, ent_in;
   logic [RES_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [RES_IDX_W-1:0]       idx_ff, idx_in;
   logic                       valid_ff, valid_in;
   logic                       at_last;

   assign at_last = (({1'b0, idx_ff} + 1'b1) == cnt_ff);
   assign free    = !valid_ff || (rsp_ready && at_last);

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = ent_ff[idx_ff].byte_val;
   assign rsp_chunk_end = ent_ff[idx_ff].chunk_end;
   assign rsp_run_end   = at_last;

   always_comb begin
      ent_in   = ent_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         idx_in = idx_ff + 1'b1;
         if (at_last) begin
            valid_in = 1'b0;
         end
      end
      if (load) begin
         ent_in   = list.ent;
         cnt_in   = list.cnt;
         idx_in   = '0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

[hw/rtl/slip_chunked_encoder.sv]
// slip_chunked_encoder: top level of the chunked slip encoder
// uses slip_enc_pkg, slip_enc_expand and slip_enc_emit
`default_nettype none

// channel | direction | ports
// req     | in        | req_valid/req_ready, req_data_byte, req_has_data, req_last_byte
// rsp     | out       | rsp_valid/rsp_ready, rsp_out_byte, rsp_chunk_end, rsp_run_end
// csr     | in        | csr_valid/csr_ready, csr_chunk_size
//
// an item is held in the input register, then its 0 to 4 encoded bytes
// are loaded at once into the output list and leave one byte per cycle while rsp_ready is high
// an item makes 0 to 4 bytes, usually 1 or 2, so the single-byte output port
// sets how fast items go through
// the next item is taken while the last byte of the previous one is taken
// a stalled output holds the list, then the input register, then drops req_ready
// reset clears frame state, fill count and sets chunk size to 20

module slip_chunked_encoder import slip_enc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_has_data,
   input  wire logic              req_last_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_chunk_end,
   output logic                   rsp_run_end,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [FILL_W-1:0] csr_chunk_size
);

   // configuration register, always writable
   logic [FILL_W-1:0] chunk_size_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_has_ff;
   logic       in_last_ff;

   slip_list_type list;
   logic          emit_free;
   logic          take;
   logic          load;

   assign csr_ready = 1'b1;

   // an item with no bytes just leaves; otherwise it waits for a free list
   assign take      = in_valid_ff && ((list.cnt == '0) || emit_free);
   assign load      = take && (list.cnt != '0);
   assign req_ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_RESET;
         in_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            chunk_size_ff <= csr_chunk_size;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_has_ff  <= req_has_data;
         in_last_ff <= req_last_byte;
      end
   end

   slip_enc_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .chunk_size (chunk_size_ff),
      .data_byte  (in_data_ff),
      .has_data   (in_has_ff),
      .last_byte  (in_last_ff),
      .take       (take),
      .list       (list)
   );

   slip_enc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .list          (list),
      .free          (emit_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_chunk_end (rsp_chunk_end),
      .rsp_run_end   (rsp_run_end)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench.sv: self-checking bench for slip_chunked_encoder with its own slip
// encoding and chunking predictor; depends on slip_enc_pkg and the encoder rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slip_enc_pkg::*;

   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_PCT      = 14;    // chance of an idle cycle on either side
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;     // input register plus up to four bytes out
   localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all

   // one encoded byte as it should leave the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       chunk_end;
      logic       run_end;
   } enc_byte_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte  = 8'h00;
   logic              req_has_data   = 1'b0;
   logic              req_last_byte  = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_chunk_end;
   logic              rsp_run_end;
   logic              csr_valid      = 1'b0;
   logic              csr_ready;
   logic [FILL_W-1:0] csr_chunk_size = '0;

   // predictor state, mirrors the block after reset
   logic [FILL_W-1:0] pred_chunk_size = CHUNK_RESET;
   logic [FILL_W-1:0] pred_fill       = '0;
   logic              pred_in_frame   = 1'b0;

   // encoded bytes still owed by the block, oldest first
   enc_byte_type expected_bytes[$];

   // run control and bookkeeping
   logic quiet        = 1'b0;   // no idling on either side while set
   logic hold_request = 1'b0;   // asks the receiver for one long hold-off
   int   errors       = 0;
   int   items_sent   = 0;
   int   bytes_seen   = 0;
   int   chunks_seen  = 0;
   int   size_writes  = 0;
   int   holds_done   = 0;
   int   stall_count  = 0;

   slip_chunked_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_has_data   (req_has_data),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_chunk_end  (rsp_chunk_end),
      .rsp_run_end    (rsp_run_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_chunk_size (csr_chunk_size)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // place one byte into the open chunk; the chunk closes when it is full
   // or when the fill counter wraps
   function automatic void put_encoded(input logic [7:0] value,
                                       input logic [FILL_W-1:0] lim);
      enc_byte_type e;
      pred_fill   = pred_fill + 1'b1;
      e.out_byte  = value;
      e.chunk_end = 1'b0;
      e.run_end   = 1'b0;
      if (pred_fill >= lim || pred_fill == '0) begin
         e.chunk_end = 1'b1;
         pred_fill   = '0;
      end
      expected_bytes.push_back(e);
   endfunction

   // work out the encoded bytes that one accepted item causes
   function automatic void encode_item(input logic [7:0] data, input logic has,
                                       input logic last);
      logic [FILL_W-1:0] lim;
      int                first;
      first = expected_bytes.size();
      // sizes below the minimum behave as the minimum
      lim = (pred_chunk_size < MIN_CHUNK) ? MIN_CHUNK : pred_chunk_size;
      // first item of a message opens the frame with END
      if (!pred_in_frame) begin
         put_encoded(FRAME_END, lim);
         pred_in_frame = 1'b1;
      end
      if (has) begin
         if (data == FRAME_END) begin
            put_encoded(FRAME_ESC, lim);
            put_encoded(FRAME_ESC_END, lim);
         end else if (data == FRAME_ESC) begin
            put_encoded(FRAME_ESC, lim);
            put_encoded(FRAME_ESC_ESC, lim);
         end else begin
            put_encoded(data, lim);
         end
      end
      if (last) begin
         // closing END shares the chunk only with two free slots left,
         // else the byte just placed closes the chunk and END goes alone;
         // with nothing placed this item the END simply closes the chunk
         if (int'(pred_fill) + 1 >= int'(lim) && expected_bytes.size() > first)
            expected_bytes[$].chunk_end = 1'b1;
         expected_bytes.push_back('{FRAME_END, 1'b1, 1'b0});
         pred_fill     = '0;
         pred_in_frame = 1'b0;
      end
      if (expected_bytes.size() > first)
         expected_bytes[$].run_end = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one item and hold it until the block takes it
   task automatic send_item(input logic [7:0] data, input logic has, input logic last);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_has_data  <= has;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_item(data, has, last);
      // items that only keep the frame open do not count as traffic
      if (has || last || !pred_in_frame)
         items_sent++;
   endtask

   // stop offering, wait for every owed byte, then let the pipe settle;
   // an item with no output may still be in flight when the queue empties
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // chunk size is only written with the block idle
   task automatic write_chunk_size(input logic [FILL_W-1:0] size);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_chunk_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid       <= 1'b0;
      pred_chunk_size  = size;
      size_writes++;
   endtask

   // payload bytes weighted toward the two bytes that need escaping
   function automatic logic [7:0] random_payload();
      case ($urandom_range(7))
         0:       return FRAME_END;
         1:       return FRAME_ESC;
         2:       return $urandom_range(1) ? FRAME_ESC_END : FRAME_ESC_ESC;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one message of len payload bytes, with the odd no-data item mixed in
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(random_payload(), 1'b1, i == len - 1);
      end
   endtask

   // mostly small chunks so that chunk boundaries hit escapes and closing ends
   function automatic logic [FILL_W-1:0] pick_chunk_size();
      case ($urandom_range(9))
         0:       return 10'd0;
         1:       return 10'd2;
         2:       return MIN_CHUNK;
         3:       return 10'd4;
         4:       return 10'd5;
         5:       return 10'($urandom_range(3, 12));
         6:       return CHUNK_RESET;
         7:       return 10'($urandom_range(13, 64));
         default: return 10'($urandom_range(6, 30));
      endcase
   endfunction

   // receiver: random stalls, no stalls while quiet, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   // compare every accepted byte against the oldest owed byte
   always @(posedge clock) begin
      enc_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_seen++;
         if (rsp_chunk_end)
            chunks_seen++;
         if (expected_bytes.size() == 0) begin
            $error("byte %02h came out with nothing owed", rsp_out_byte);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_chunk_end !== want.chunk_end) begin
               $error("chunk_end: expected %0b, got %0b", want.chunk_end, rsp_chunk_end);
               errors++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0b, got %0b", want.run_end, rsp_run_end);
               errors++;
            end
         end
      end
   end

   // watchdog: too long with no handshake on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count == STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // reset chunk size: empty message, frame kept open with no data,
   // extreme bytes and both escapes
   task automatic test_reset_defaults();
      send_item(8'h00, 1'b0, 1'b1);        // empty message: END then closing END
      send_item(8'hA5, 1'b0, 1'b0);        // no data opens the frame
      send_item(8'h5A, 1'b0, 1'b0);        // no data, frame open: nothing out
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(FRAME_END, 1'b1, 1'b0);
      send_item(FRAME_ESC, 1'b1, 1'b0);
      send_item(FRAME_ESC_END, 1'b1, 1'b0);
      send_item(FRAME_ESC_ESC, 1'b1, 1'b1);
   endtask

   // minimum chunk: split escape pairs, closing END pushed to its own chunk,
   // and sizes below the minimum
   task automatic test_small_chunks();
      write_chunk_size(MIN_CHUNK);
      send_item(8'h11, 1'b1, 1'b0);        // END, 11: chunk one short of full
      send_item(8'h00, 1'b0, 1'b1);        // no data, nearly full: END closes it
      send_item(8'h22, 1'b1, 1'b0);
      send_item(FRAME_END, 1'b1, 1'b0);    // ESC closes chunk, ESC_END opens next
      send_item(8'h33, 1'b1, 1'b1);        // 33 closes chunk, END alone
      write_chunk_size(10'd0);
      send_item(FRAME_ESC, 1'b1, 1'b1);
      write_chunk_size(10'd2);
      send_item(8'h80, 1'b1, 1'b1);
   endtask

   // chunk size lowered below the fill of an open chunk mid-message
   task automatic test_size_lowered();
      write_chunk_size(CHUNK_RESET);
      for (int i = 0; i < 6; i++)
         send_item(8'h40 + 8'(i), 1'b1, 1'b0);
      write_chunk_size(10'd5);
      send_item(8'h5A, 1'b1, 1'b0);        // next byte closes the chunk
      send_item(8'h01, 1'b1, 1'b1);
   endtask

   // a large chunk size and the largest value the field holds
   task automatic test_largest_chunks();
      write_chunk_size(10'd514);
      send_message(30);
      write_chunk_size(10'd1023);
      send_message(30);
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_output_holdoff();
      write_chunk_size(10'd7);
      quiet        = 1'b1;
      hold_request = 1'b1;
      repeat (4) send_message(8);
      quiet = 1'b0;
      wait_drained();
   endtask

   // random messages over a spread of chunk sizes; one phase runs with no idling
   task automatic test_random_traffic();
      int phase;
      int target;
      phase  = 0;
      target = items_sent + 90;
      while (items_sent < target) begin
         write_chunk_size(pick_chunk_size());
         quiet = (phase == 1);
         repeat (quiet ? 10 : $urandom_range(2, 5)) begin
            if ($urandom_range(99) < 8)
               send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            else
               send_message($urandom_range(1, 10));
         end
         phase++;
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_small_chunks();
      test_size_lowered();
      test_largest_chunks();
      test_output_holdoff();
      test_random_traffic();
      wait_drained();

      if (expected_bytes.size() != 0) begin
         $error("%0d encoded bytes never came out", expected_bytes.size());
         errors++;
      end

      $display("run: %0d items over %0d chunk size writes, %0d bytes in %0d chunks",
               items_sent, size_writes, bytes_seen, chunks_seen);
      $display("run: %0d receiver hold-off(s) of %0d cycles, %0d mismatches",
               holds_done, HOLD_CYCLES, errors);
      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
